>>> rtl/prim_mst_weight_product_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the weight-product MST core
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PRIM_MST_WEIGHT_PRODUCT_CORE_DEFINES_SVH
`define PRIM_MST_WEIGHT_PRODUCT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define MWP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mwp assertion failed");
// expr must never be true outside reset
`define MWP_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("mwp forbidden condition seen");
`else
`define MWP_ASSERT(lbl, clk, rst, prop)
`define MWP_ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

>>> rtl/mwp_pkg.sv
// ----------------------------------------------------------------------------
// mwp_pkg
// Shared constants and types of the weight-product MST core.
// ----------------------------------------------------------------------------
package mwp_pkg;

   localparam int MAX_VERTICES      = 64;
   localparam int VERTEX_BITS       = 6;
   localparam int VCOUNT_BITS       = 7;
   localparam int WEIGHT_BITS       = 16;
   localparam int KEY_BITS          = WEIGHT_BITS + 1;
   localparam int PRODUCT_BITS      = 64;
   localparam int MAX_EDGES_DEFAULT = 256;
   localparam int CSR_INDEX_BITS    = 1;
   localparam int CSR_DATA_BITS     = 7;

   localparam logic [KEY_BITS-1:0] KEY_INF = KEY_BITS'(1) << WEIGHT_BITS;

   localparam logic KIND_EDGE    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_VERTEX_COUNT  = 1'b0,
      CSR_SOURCE_VERTEX = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                   start;
      logic                   clear;
      logic [WEIGHT_BITS-1:0] operand;
   } mwp_mul_ctl_type;

   typedef struct packed {
      logic busy;
      logic overflow;
      logic zero_seen;
   } mwp_mul_sts_type;

endpackage

>>> rtl/mwp_mul.sv
// ----------------------------------------------------------------------------
// mwp_mul
// Running product mod 2^64, one 16x16 partial product per cycle.
// ----------------------------------------------------------------------------
module mwp_mul (
   input  logic                           clock,
   input  logic                           reset,
   input  mwp_pkg::mwp_mul_ctl_type       ctl,
   output mwp_pkg::mwp_mul_sts_type       sts,
   output logic [mwp_pkg::PRODUCT_BITS-1:0] product
);
   import mwp_pkg::*;

   localparam int ACC_BITS = PRODUCT_BITS + WEIGHT_BITS;

   logic [PRODUCT_BITS-1:0]  prod_ff;
   logic [ACC_BITS-1:0]      acc_ff;
   logic [ACC_BITS-1:0]      acc_in;
   logic [WEIGHT_BITS-1:0]   k_ff;
   logic [1:0]               step_ff;
   logic                     busy_ff;
   logic                     ovf_ff;
   logic                     zero_ff;
   logic [2*WEIGHT_BITS-1:0] pp;

   // one slice of the product times the operand, shifted into place
   assign pp     = prod_ff[{step_ff, 4'b0000} +: WEIGHT_BITS] * k_ff;
   assign acc_in = acc_ff + (ACC_BITS'(pp) << {step_ff, 4'b0000});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         ovf_ff  <= 1'b0;
         zero_ff <= 1'b0;
         prod_ff <= PRODUCT_BITS'(1);
      end else if (ctl.clear) begin
         busy_ff <= 1'b0;
         ovf_ff  <= 1'b0;
         zero_ff <= 1'b0;
         prod_ff <= PRODUCT_BITS'(1);
      end else if (ctl.start) begin
         k_ff    <= ctl.operand;
         acc_ff  <= '0;
         step_ff <= 2'd0;
         busy_ff <= 1'b1;
         if (ctl.operand == '0) begin
            zero_ff <= 1'b1;
         end
      end else if (busy_ff) begin
         acc_ff  <= acc_in;
         step_ff <= step_ff + 2'd1;
         if (step_ff == 2'd3) begin
            prod_ff <= acc_in[PRODUCT_BITS-1:0];
            busy_ff <= 1'b0;
            if (|acc_in[ACC_BITS-1:PRODUCT_BITS]) begin
               ovf_ff <= 1'b1;
            end
         end
      end
   end

   assign sts.busy      = busy_ff;
   assign sts.overflow  = ovf_ff;
   assign sts.zero_seen = zero_ff;
   assign product       = prod_ff;

endmodule

>>> rtl/prim_mst_weight_product_core.sv
// ----------------------------------------------------------------------------
// prim_mst_weight_product_core
// Edge table loader and Prim solver; emits tree edges and a weight product.
// ----------------------------------------------------------------------------
// Edge items (last_edge low) are taken while busy stays low, one per cycle.
// The last item holds busy through setup, a key scan per join, a relax of every
// stored edge per join (address, fetch, update) and a walk over the vertices that
// outputs each tree edge and waits on the product unit; a source outside the graph
// goes from setup straight to the summary. Reset clears control, count and flag,
// sets one vertex and source 0; results are one-cycle strobes on rsp_valid.
module prim_mst_weight_product_core #(
   parameter int MAX_EDGES = mwp_pkg::MAX_EDGES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // item channel
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_edge_valid,
   input  logic [mwp_pkg::VERTEX_BITS-1:0]   req_end_a,
   input  logic [mwp_pkg::VERTEX_BITS-1:0]   req_end_b,
   input  logic [mwp_pkg::WEIGHT_BITS-1:0]   req_weight,
   input  logic                              req_last_edge,
   // register write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mwp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [mwp_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   // result channel
   output logic                              rsp_valid,
   output logic                              rsp_item_kind,
   output logic [mwp_pkg::VERTEX_BITS-1:0]   rsp_parent_vertex,
   output logic [mwp_pkg::VERTEX_BITS-1:0]   rsp_child_vertex,
   output logic [mwp_pkg::WEIGHT_BITS-1:0]   rsp_edge_weight,
   output logic [mwp_pkg::PRODUCT_BITS-1:0]  rsp_weight_product,
   output logic                              rsp_product_overflow,
   output logic                              rsp_edges_dropped,
   output logic                              rsp_result_last
);
   import mwp_pkg::*;

`include "prim_mst_weight_product_core_defines.svh"

   localparam int ECW = $clog2(MAX_EDGES + 1);
   localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int EDGE_BITS = 2 * VERTEX_BITS + WEIGHT_BITS;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SETUP,
      S_SCAN,
      S_R_ADDR,
      S_R_EDGE,
      S_R_UPD,
      S_E_CHECK,
      S_E_OUT,
      S_E_MUL,
      S_SUMMARY
   } state_type;

   state_type state_ff;

   // configuration
   logic [VCOUNT_BITS-1:0] vc_ff;
   logic [VERTEX_BITS-1:0] src_ff;
   logic [VCOUNT_BITS-1:0] nv;

   // edge table
   logic [EDGE_BITS-1:0] edge_mem [MAX_EDGES];
   logic [EDGE_BITS-1:0] edge_rd_ff;
   logic [ECW-1:0]       edge_cnt_ff;
   logic [ECW-1:0]       edge_idx_ff;
   logic                 drop_ff;
   logic                 edge_we;
   logic                 edge_ok;

   // per-vertex key and parent store
   logic [WEIGHT_BITS-1:0] key_mem [MAX_VERTICES];
   logic [VERTEX_BITS-1:0] par_mem [MAX_VERTICES];
   logic [WEIGHT_BITS-1:0] key_rd_ff;
   logic [VERTEX_BITS-1:0] par_rd_ff;
   logic [VERTEX_BITS-1:0] key_raddr;
   logic                   key_we;
   logic                   par_we;
   logic [VERTEX_BITS-1:0] key_waddr;
   logic [WEIGHT_BITS-1:0] key_wdata;
   logic [MAX_VERTICES-1:0] in_tree_ff;
   logic [MAX_VERTICES-1:0] touched_ff;

   // sequencer working registers
   logic [VCOUNT_BITS-1:0] cnt_ff;
   logic                   pvalid_ff;
   logic [VERTEX_BITS-1:0] pidx_ff;
   logic [KEY_BITS-1:0]    best_ff;
   logic [VERTEX_BITS-1:0] best_u_ff;
   logic                   found_ff;
   logic [VERTEX_BITS-1:0] u_ff;
   logic [VERTEX_BITS-1:0] to_ff;
   logic                   to_ok_ff;
   logic [WEIGHT_BITS-1:0] w_ff;

   // decoded edge under relax
   logic [VERTEX_BITS-1:0] ed_a;
   logic [VERTEX_BITS-1:0] ed_b;
   logic [WEIGHT_BITS-1:0] ed_w;
   logic                   match_a;
   logic                   match_b;
   logic [VERTEX_BITS-1:0] ed_to;

   logic [KEY_BITS-1:0]    scan_key;
   logic [KEY_BITS-1:0]    upd_key;
   logic                   relax_hit;
   logic                   accept;

   // result registers
   logic                    rsp_valid_ff;
   logic                    rsp_kind_ff;
   logic [VERTEX_BITS-1:0]  rsp_parent_ff;
   logic [VERTEX_BITS-1:0]  rsp_child_ff;
   logic [WEIGHT_BITS-1:0]  rsp_weight_ff;
   logic [PRODUCT_BITS-1:0] rsp_product_ff;
   logic                    rsp_ovf_ff;
   logic                    rsp_drop_ff;
   logic                    rsp_last_ff;

   // product unit
   mwp_mul_ctl_type         mul_ctl;
   mwp_mul_sts_type         mul_sts;
   logic [PRODUCT_BITS-1:0] mul_product;

   mwp_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mul_ctl),
      .sts     (mul_sts),
      .product (mul_product)
   );

   assign busy      = (state_ff != S_IDLE);
   // hold register writes off while a solve is running
   assign csr_ready = !busy;
   assign accept    = start && !busy;

   // zero vertices acts as one, more than the table holds clamps to the table
   always_comb begin
      if (vc_ff == '0) begin
         nv = VCOUNT_BITS'(1);
      end else if (vc_ff > VCOUNT_BITS'(MAX_VERTICES)) begin
         nv = VCOUNT_BITS'(MAX_VERTICES);
      end else begin
         nv = vc_ff;
      end
   end

   // an edge is stored only with both ends in range and room in the table
   assign edge_ok = ({1'b0, req_end_a} < nv) && ({1'b0, req_end_b} < nv) &&
                    (edge_cnt_ff != ECW'(MAX_EDGES));
   assign edge_we = accept && req_edge_valid && edge_ok;

   // decode the fetched edge and pick the far end if it touches u
   assign ed_a    = edge_rd_ff[EDGE_BITS-1 -: VERTEX_BITS];
   assign ed_b    = edge_rd_ff[WEIGHT_BITS +: VERTEX_BITS];
   assign ed_w    = edge_rd_ff[WEIGHT_BITS-1:0];
   assign match_a = (ed_a == u_ff);
   assign match_b = (ed_b == u_ff);
   assign ed_to   = match_a ? ed_b : ed_a;

   // a vertex never touched in this solve reads as infinity
   assign scan_key = touched_ff[pidx_ff] ? {1'b0, key_rd_ff} : KEY_INF;
   assign upd_key  = touched_ff[to_ff] ? {1'b0, key_rd_ff} : KEY_INF;
   assign relax_hit = to_ok_ff && ({1'b0, to_ff} < nv) && !in_tree_ff[to_ff] &&
                      ({1'b0, w_ff} < upd_key);

   // single read address into the key and parent store
   always_comb begin
      case (state_ff)
         S_R_EDGE:  key_raddr = ed_to;
         S_E_CHECK: key_raddr = cnt_ff[VERTEX_BITS-1:0];
         default:   key_raddr = cnt_ff[VERTEX_BITS-1:0];
      endcase
   end

   // key writes: seed the source at setup, lower a key on a relax hit
   always_comb begin
      key_we    = 1'b0;
      par_we    = 1'b0;
      key_waddr = src_ff;
      key_wdata = '0;
      case (state_ff)
         S_SETUP: begin
            key_we = ({1'b0, src_ff} < nv);
         end
         S_R_UPD: begin
            key_we    = relax_hit;
            par_we    = relax_hit;
            key_waddr = to_ff;
            key_wdata = w_ff;
         end
         default: begin
            key_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      mul_ctl.start   = (state_ff == S_E_OUT);
      mul_ctl.clear   = (state_ff == S_SETUP);
      mul_ctl.operand = key_rd_ff;
   end

   // memories
   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_cnt_ff[EIW-1:0]] <= {req_end_a, req_end_b, req_weight};
      end
      edge_rd_ff <= edge_mem[edge_idx_ff[EIW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr] <= key_wdata;
      end
      if (par_we) begin
         par_mem[key_waddr] <= u_ff;
      end
      key_rd_ff <= key_mem[key_raddr];
      par_rd_ff <= par_mem[key_raddr];
   end

   // sequencer, state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vc_ff        <= VCOUNT_BITS'(1);
         src_ff       <= '0;
         edge_cnt_ff  <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pvalid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;

         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_VERTEX_COUNT:  vc_ff  <= csr_wdata[VCOUNT_BITS-1:0];
               CSR_SOURCE_VERTEX: src_ff <= csr_wdata[VERTEX_BITS-1:0];
               default:           vc_ff  <= vc_ff;
            endcase
         end

         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  // append or drop the carried edge, then solve on the last item
                  if (req_edge_valid) begin
                     if (edge_ok) begin
                        edge_cnt_ff <= edge_cnt_ff + ECW'(1);
                     end else begin
                        drop_ff <= 1'b1;
                     end
                  end
                  if (req_last_edge) begin
                     state_ff <= S_SETUP;
                  end
               end
            end

            S_SETUP: begin
               in_tree_ff <= '0;
               cnt_ff     <= '0;
               pvalid_ff  <= 1'b0;
               best_ff    <= KEY_INF;
               found_ff   <= 1'b0;
               if ({1'b0, src_ff} < nv) begin
                  touched_ff <= MAX_VERTICES'(1) << src_ff;
                  state_ff   <= S_SCAN;
               end else begin
                  // source out of range: nothing reached, summary only
                  touched_ff <= '0;
                  state_ff   <= S_SUMMARY;
               end
            end

            S_SCAN: begin
               // issue one key read a cycle, judge the one read last cycle
               if (cnt_ff < nv) begin
                  cnt_ff <= cnt_ff + VCOUNT_BITS'(1);
               end
               pvalid_ff <= (cnt_ff < nv);
               pidx_ff   <= cnt_ff[VERTEX_BITS-1:0];
               if (pvalid_ff && !in_tree_ff[pidx_ff] && (scan_key < best_ff)) begin
                  best_ff   <= scan_key;
                  best_u_ff <= pidx_ff;
                  found_ff  <= 1'b1;
               end
               if ((cnt_ff == nv) && !pvalid_ff) begin
                  if (found_ff) begin
                     // join the lowest key vertex and relax its edges
                     in_tree_ff[best_u_ff] <= 1'b1;
                     u_ff        <= best_u_ff;
                     edge_idx_ff <= '0;
                     cnt_ff      <= '0;
                     best_ff     <= KEY_INF;
                     found_ff    <= 1'b0;
                     if (edge_cnt_ff == '0) begin
                        state_ff <= S_SCAN;
                     end else begin
                        state_ff <= S_R_ADDR;
                     end
                  end else begin
                     cnt_ff   <= '0;
                     state_ff <= S_E_CHECK;
                  end
               end
            end

            S_R_ADDR: begin
               state_ff <= S_R_EDGE;
            end

            S_R_EDGE: begin
               to_ff    <= ed_to;
               to_ok_ff <= match_a || match_b;
               w_ff     <= ed_w;
               state_ff <= S_R_UPD;
            end

            S_R_UPD: begin
               if (relax_hit) begin
                  touched_ff[to_ff] <= 1'b1;
               end
               edge_idx_ff <= edge_idx_ff + ECW'(1);
               if (ECW'(edge_idx_ff + ECW'(1)) == edge_cnt_ff) begin
                  cnt_ff   <= '0;
                  best_ff  <= KEY_INF;
                  found_ff <= 1'b0;
                  state_ff <= S_SCAN;
               end else begin
                  state_ff <= S_R_ADDR;
               end
            end

            S_E_CHECK: begin
               // walk children in index order, skip source and unreached ones
               if (cnt_ff == nv) begin
                  state_ff <= S_SUMMARY;
               end else if (touched_ff[cnt_ff[VERTEX_BITS-1:0]] &&
                            (cnt_ff[VERTEX_BITS-1:0] != src_ff)) begin
                  state_ff <= S_E_OUT;
               end else begin
                  cnt_ff <= cnt_ff + VCOUNT_BITS'(1);
               end
            end

            S_E_OUT: begin
               rsp_valid_ff   <= 1'b1;
               rsp_kind_ff    <= KIND_EDGE;
               rsp_parent_ff  <= par_rd_ff;
               rsp_child_ff   <= cnt_ff[VERTEX_BITS-1:0];
               rsp_weight_ff  <= key_rd_ff;
               rsp_product_ff <= '0;
               rsp_ovf_ff     <= 1'b0;
               rsp_drop_ff    <= 1'b0;
               rsp_last_ff    <= 1'b0;
               cnt_ff         <= cnt_ff + VCOUNT_BITS'(1);
               state_ff       <= S_E_MUL;
            end

            S_E_MUL: begin
               // hold until the product unit has folded in this weight
               if (!mul_sts.busy) begin
                  state_ff <= S_E_CHECK;
               end
            end

            S_SUMMARY: begin
               rsp_valid_ff   <= 1'b1;
               rsp_kind_ff    <= KIND_SUMMARY;
               rsp_parent_ff  <= '0;
               rsp_child_ff   <= '0;
               rsp_weight_ff  <= '0;
               rsp_product_ff <= mul_product;
               rsp_ovf_ff     <= mul_sts.overflow && !mul_sts.zero_seen;
               rsp_drop_ff    <= drop_ff;
               rsp_last_ff    <= 1'b1;
               // drop the edge table and flag for the next run
               edge_cnt_ff    <= '0;
               drop_ff        <= 1'b0;
               state_ff       <= S_IDLE;
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_item_kind        = rsp_kind_ff;
   assign rsp_parent_vertex    = rsp_parent_ff;
   assign rsp_child_vertex     = rsp_child_ff;
   assign rsp_edge_weight      = rsp_weight_ff;
   assign rsp_weight_product   = rsp_product_ff;
   assign rsp_product_overflow = rsp_ovf_ff;
   assign rsp_edges_dropped    = rsp_drop_ff;
   assign rsp_result_last      = rsp_last_ff;

   `MWP_ASSERT(a_edge_rsp_in_solve, clock, reset, rsp_valid && (rsp_item_kind == KIND_EDGE) |-> busy)
   `MWP_ASSERT(a_summary_ends_run, clock, reset, rsp_valid && rsp_result_last |-> !busy)
   `MWP_ASSERT(a_last_starts_solve, clock, reset, start && !busy && req_last_edge |=> busy)
   `MWP_ASSERT_NEVER(a_edge_count_bound, clock, reset, edge_cnt_ff > ECW'(MAX_EDGES))

endmodule

>>> tb/sv/prim_mst_weight_product_core_tb.sv
// ----------------------------------------------------------------------------
// prim_mst_weight_product_core_tb
// Loads edge sets into the MST core under several vertex counts and sources,
// runs each solve, and checks every tree edge and the weight-product summary
// against an in-bench Prim predictor, with random input gaps.
// ----------------------------------------------------------------------------
module prim_mst_weight_product_core_tb;
   import mwp_pkg::*;

   localparam int TABLE_DEPTH = MAX_EDGES_DEFAULT;
   localparam int KEY_NONE    = 1 << WEIGHT_BITS;
   localparam int STALL_LIMIT = 200000;

   typedef struct {
      bit                   has_edge;
      bit [VERTEX_BITS-1:0] a;
      bit [VERTEX_BITS-1:0] b;
      bit [WEIGHT_BITS-1:0] w;
      bit                   last;
   } edge_item_type;

   typedef struct {
      bit                    kind;
      bit [VERTEX_BITS-1:0]  parent;
      bit [VERTEX_BITS-1:0]  child;
      bit [WEIGHT_BITS-1:0]  wt;
      bit [PRODUCT_BITS-1:0] product;
      bit                    ovf;
      bit                    dropped;
      bit                    last;
   } tree_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_edge_valid = 1'b0;
   logic [VERTEX_BITS-1:0] req_end_a = '0;
   logic [VERTEX_BITS-1:0] req_end_b = '0;
   logic [WEIGHT_BITS-1:0] req_weight = '0;
   logic req_last_edge = 1'b0;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;
   logic rsp_valid;
   logic rsp_item_kind;
   logic [VERTEX_BITS-1:0] rsp_parent_vertex;
   logic [VERTEX_BITS-1:0] rsp_child_vertex;
   logic [WEIGHT_BITS-1:0] rsp_edge_weight;
   logic [PRODUCT_BITS-1:0] rsp_weight_product;
   logic rsp_product_overflow;
   logic rsp_edges_dropped;
   logic rsp_result_last;

   prim_mst_weight_product_core dut (.*);

   always #5 clock = ~clock;

   // predictor state: edge table, drop flag and register shadows
   bit [VERTEX_BITS-1:0] tbl_a [TABLE_DEPTH];
   bit [VERTEX_BITS-1:0] tbl_b [TABLE_DEPTH];
   bit [WEIGHT_BITS-1:0] tbl_w [TABLE_DEPTH];
   int unsigned tbl_count = 0;
   bit          tbl_dropped = 0;
   bit [VCOUNT_BITS-1:0] shadow_vcount = 1;
   bit [VERTEX_BITS-1:0] shadow_source = 0;

   edge_item_type   pending_items[$];
   tree_result_type expected_results[$];
   edge_item_type   cur_item;
   bit              item_taken = 0;
   bit              csr_taken = 0;
   bit              failed = 0;
   bit              quiet = 0;
   int              gap_left = 0;
   int              stall_cycles = 0;

   // Apply one accepted transfer: store or drop its edge, and on the last
   // item grow the tree and queue the edges plus the summary.
   function automatic void predict_tree(input edge_item_type it);
      int nv, u, bk, i, e;
      int key [MAX_VERTICES];
      int par [MAX_VERTICES];
      bit done [MAX_VERTICES];
      bit [PRODUCT_BITS-1:0] prod;
      bit ovf, zero_seen;
      tree_result_type r;
      nv = (shadow_vcount == 0) ? 1 : (shadow_vcount > MAX_VERTICES) ? MAX_VERTICES
                                                                     : shadow_vcount;
      prod = 1;
      ovf = 0;
      zero_seen = 0;
      if (it.has_edge) begin
         if (it.a >= nv || it.b >= nv || tbl_count >= TABLE_DEPTH) begin
            tbl_dropped = 1;
         end else begin
            tbl_a[tbl_count] = it.a;
            tbl_b[tbl_count] = it.b;
            tbl_w[tbl_count] = it.w;
            tbl_count++;
         end
      end
      if (!it.last) return;
      for (i = 0; i < nv; i++) begin
         key[i] = KEY_NONE;
         par[i] = -1;
         done[i] = 0;
      end
      if (shadow_source < nv) begin
         key[shadow_source] = 0;
         while (1) begin
            u = nv;
            bk = KEY_NONE;
            for (i = 0; i < nv; i++)
               if (!done[i] && key[i] < bk) begin
                  bk = key[i];
                  u = i;
               end
            if (u >= nv) break;
            done[u] = 1;
            // relax both directions; strict less-than keeps the first parent
            for (e = 0; e < tbl_count; e++) begin
               if (tbl_a[e] == u && tbl_b[e] < nv && !done[tbl_b[e]]
                   && tbl_w[e] < key[tbl_b[e]]) begin
                  key[tbl_b[e]] = tbl_w[e];
                  par[tbl_b[e]] = u;
               end
               if (tbl_b[e] == u && tbl_a[e] < nv && !done[tbl_a[e]]
                   && tbl_w[e] < key[tbl_a[e]]) begin
                  key[tbl_a[e]] = tbl_w[e];
                  par[tbl_a[e]] = u;
               end
            end
         end
      end
      for (i = 0; i < nv; i++) begin
         if (i == shadow_source || par[i] < 0) continue;
         if (key[i] == 0) zero_seen = 1;
         else if (prod > ({PRODUCT_BITS{1'b1}} / key[i])) ovf = 1;
         prod = prod * key[i];
         r = '{KIND_EDGE, VERTEX_BITS'(par[i]), VERTEX_BITS'(i), WEIGHT_BITS'(key[i]),
               '0, 1'b0, 1'b0, 1'b0};
         expected_results = {expected_results, r};
      end
      r = '{KIND_SUMMARY, '0, '0, '0, prod, ovf && !zero_seen, tbl_dropped, 1'b1};
      expected_results = {expected_results, r};
      tbl_count = 0;
      tbl_dropped = 0;
   endfunction

   // Driver: hold the item until its transfer, then advance or idle a burst.
   always @(negedge clock) begin
      if (!reset && (!start || item_taken)) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (pending_items.size() > 0) begin
            cur_item = pending_items.pop_front();
            req_edge_valid <= cur_item.has_edge;
            req_end_a <= cur_item.a;
            req_end_b <= cur_item.b;
            req_weight <= cur_item.w;
            req_last_edge <= cur_item.last;
            start <= 1'b1;
            if (!quiet && $urandom_range(0, 4) == 0) gap_left <= $urandom_range(1, 6);
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: record transfers, predict, and check every result strobe.
   always @(posedge clock) begin
      tree_result_type x;
      bit took_item;
      bit took_csr;
      took_item = 1'b0;
      took_csr = 1'b0;
      if (!reset) begin
         if (start && !busy) begin
            predict_tree(cur_item);
            took_item = 1'b1;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index_type'(csr_index) == CSR_VERTEX_COUNT) shadow_vcount = csr_wdata;
            else shadow_source = csr_wdata[VERTEX_BITS-1:0];
            took_csr = 1'b1;
         end
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result: kind %0d child %0d", rsp_item_kind,
                      rsp_child_vertex);
               failed = 1;
            end else begin
               x = expected_results.pop_front();
               if (rsp_item_kind !== x.kind) begin
                  $error("item_kind exp %0d got %0d", x.kind, rsp_item_kind);
                  failed = 1;
               end
               if (rsp_parent_vertex !== x.parent) begin
                  $error("parent_vertex exp %0d got %0d", x.parent, rsp_parent_vertex);
                  failed = 1;
               end
               if (rsp_child_vertex !== x.child) begin
                  $error("child_vertex exp %0d got %0d", x.child, rsp_child_vertex);
                  failed = 1;
               end
               if (rsp_edge_weight !== x.wt) begin
                  $error("edge_weight exp %0d got %0d", x.wt, rsp_edge_weight);
                  failed = 1;
               end
               if (rsp_weight_product !== x.product) begin
                  $error("weight_product exp %h got %h", x.product, rsp_weight_product);
                  failed = 1;
               end
               if (rsp_product_overflow !== x.ovf) begin
                  $error("product_overflow exp %0d got %0d", x.ovf, rsp_product_overflow);
                  failed = 1;
               end
               if (rsp_edges_dropped !== x.dropped) begin
                  $error("edges_dropped exp %0d got %0d", x.dropped, rsp_edges_dropped);
                  failed = 1;
               end
               if (rsp_result_last !== x.last) begin
                  $error("result_last exp %0d got %0d", x.last, rsp_result_last);
                  failed = 1;
               end
            end
         end
         if (took_item || took_csr || rsp_valid) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
      item_taken <= took_item;
      csr_taken <= took_csr;
   end

   task automatic push_edge(input bit has_edge, input int a, input int b, input int w,
                            input bit last);
      edge_item_type it;
      it = '{has_edge, VERTEX_BITS'(a), VERTEX_BITS'(b), WEIGHT_BITS'(w), last};
      pending_items = {pending_items, it};
   endtask

   // Wait for the sender to drain and every result to arrive, then let the
   // core settle before touching registers.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_items.size() > 0 || start || gap_left > 0
             || expected_results.size() > 0 || busy);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input int data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_BITS'(data);
      do @(negedge clock);
      while (!csr_taken);
      csr_valid <= 1'b0;
   endtask

   task automatic set_graph(input int vcount, input int source);
      wait_drained();
      write_csr(CSR_VERTEX_COUNT, vcount);
      write_csr(CSR_SOURCE_VERTEX, source);
   endtask

   initial begin
      int phase, n, k, nv, a, b, w;
      bit has_edge;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset config: single vertex, bare go gives product one
      push_edge(0, 0, 0, 0, 1);

      // ties, self loop, out-of-range drop, bare item, edge on the go item
      set_graph(4, 0);
      push_edge(1, 0, 1, 5, 0);
      push_edge(1, 1, 2, 3, 0);
      push_edge(1, 0, 2, 3, 0);
      push_edge(1, 2, 3, 16'hFFFF, 0);
      push_edge(1, 3, 3, 7, 0);
      push_edge(1, 0, 5, 1, 0);
      push_edge(0, 63, 63, 16'hFFFF, 0);
      push_edge(1, 1, 3, 2, 1);

      // full width vertices, top source, product overflow
      set_graph(64, 63);
      push_edge(1, 63, 0, 16'hFFFF, 0);
      push_edge(1, 0, 1, 16'hFFFF, 0);
      push_edge(1, 1, 2, 16'hFFFF, 0);
      push_edge(1, 2, 3, 16'hFFFF, 0);
      push_edge(1, 4, 3, 16'hFFFE, 0);
      push_edge(0, 0, 0, 0, 1);

      // count above the maximum, zero weight in the tree
      set_graph(127, 5);
      push_edge(1, 5, 6, 0, 0);
      push_edge(1, 6, 7, 9, 1);

      // zero count acts as one vertex
      set_graph(0, 0);
      push_edge(1, 0, 0, 4, 1);

      // source outside the graph: summary only
      set_graph(3, 10);
      push_edge(1, 0, 1, 4, 1);

      // table overflow
      set_graph(4, 1);
      for (k = 0; k < TABLE_DEPTH + 3; k++)
         push_edge(1, $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 65535),
                   k == TABLE_DEPTH + 2);

      // random graphs, mostly in range; no idling in the last phases
      for (phase = 0; phase < 6; phase++) begin
         k = $urandom_range(0, 9);
         nv = (k == 0) ? 64 : (k == 1) ? 127 : (k == 2) ? 0 : $urandom_range(2, 12);
         n = (nv == 0) ? 1 : (nv > 64) ? 64 : nv;
         set_graph(nv, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                                   : $urandom_range(0, n - 1));
         if (phase >= 4) quiet = 1;
         k = $urandom_range(1, 4);
         for (int j = 0; j < k; j++) begin
            if (j == k - 1) has_edge = ($urandom_range(0, 1) == 1);
            else has_edge = ($urandom_range(0, 19) != 0);
            if ($urandom_range(0, 9) == 0) begin
               a = $urandom_range(0, 63);
               b = $urandom_range(0, 63);
            end else begin
               a = $urandom_range(0, n - 1);
               b = $urandom_range(0, n - 1);
            end
            w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 65535);
            push_edge(has_edge, a, b, w, j == k - 1);
         end
      end

      wait_drained();
      if (!failed) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
